[src/fpa_pkg.sv]
// Shared types and constants for the Q24.8 fixed-point ALU.
// Depends on nothing; every other file uses it by scoped names.
package fpa_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FieldW    = 32;
  localparam int unsigned CmdW      = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_e;

  // Control that travels beside the quotient out of the divider.
  typedef struct packed {
    logic valid;
    logic div_zero;
  } div_ctl_t;

endpackage

[src/fpa_div.sv]
// Pipelined restoring divider, one quotient bit per stage, signed operands.
// Depends on fpa_pkg for the control struct.
module fpa_div #(
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = fpa_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output fpa_pkg::div_ctl_t            ctl_o,
  output logic signed [DATA_WIDTH-1:0] quot_o
);

  localparam int unsigned NumW = DATA_WIDTH + FRAC_BITS;

  // Per-stage state: numerator bits shift out the top while quotient bits enter below.
  logic [NumW-1:0]       num_q [NumW+1];
  logic [DATA_WIDTH-1:0] rem_q [NumW+1];
  logic [DATA_WIDTH-1:0] den_q [NumW+1];
  logic                  neg_q [NumW+1];
  logic                  dz_q  [NumW+1];
  logic                  vld_q [NumW+1];

  logic [DATA_WIDTH-1:0] abs_a, abs_b;
  assign abs_a = a_i[DATA_WIDTH-1] ? DATA_WIDTH'(-a_i) : DATA_WIDTH'(a_i);
  assign abs_b = b_i[DATA_WIDTH-1] ? DATA_WIDTH'(-b_i) : DATA_WIDTH'(b_i);

  // Entry stage takes magnitudes and the sign of the quotient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= {abs_a, FRAC_BITS'(0)};
    rem_q[0] <= '0;
    den_q[0] <= abs_b;
    neg_q[0] <= a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
    dz_q[0]  <= (b_i == '0);
  end

  // One trial subtraction per stage.
  for (genvar k = 1; k <= NumW; k++) begin : g_stage
    logic [DATA_WIDTH:0] trial;
    logic                fits;
    assign trial = {rem_q[k-1], num_q[k-1][NumW-1]};
    assign fits  = (trial >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= fits ? DATA_WIDTH'(trial - {1'b0, den_q[k-1]}) : trial[DATA_WIDTH-1:0];
      num_q[k] <= {num_q[k-1][NumW-2:0], fits};
      den_q[k] <= den_q[k-1];
      neg_q[k] <= neg_q[k-1];
      dz_q[k]  <= dz_q[k-1];
    end
  end

  // Final stage applies the sign and the divide-by-zero rule.
  logic [DATA_WIDTH-1:0] q_mag;
  assign q_mag = num_q[NumW][DATA_WIDTH-1:0];

  logic              out_vld_q, out_dz_q;
  logic signed [DATA_WIDTH-1:0] quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_dz_q <= dz_q[NumW];
    if (dz_q[NumW]) begin
      quot_q <= '0;
    end else if (neg_q[NumW]) begin
      quot_q <= DATA_WIDTH'(-q_mag);
    end else begin
      quot_q <= q_mag;
    end
  end

  assign ctl_o.valid    = out_vld_q;
  assign ctl_o.div_zero = out_dz_q;
  assign quot_o         = quot_q;

endmodule

[src/fixed_point_alu_core.sv]
// Top level of the Q24.8 fixed-point ALU: input stage, simple ops, multiplier, divider, delay line.
// Depends on fpa_pkg and fpa_div.
// Each beat goes from start through the input register, stages 1 and 2, the delay line and the output register.
// Throughput: one beat per cycle; the divider has one stage per quotient bit.
// busy is always low, and results cannot be stalled by the receiver.
// Reset clears all valid bits; no result appears until a beat has gone through.
module fixed_point_alu_core #(
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = fpa_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fpa_pkg::CmdW-1:0]           cmd_i,
  input  logic signed [fpa_pkg::FieldW-1:0]  operand_a_i,
  input  logic signed [fpa_pkg::FieldW-1:0]  operand_b_i,
  output logic                               result_valid_o,
  output logic signed [fpa_pkg::FieldW-1:0]  result_value_o,
  output logic                               compare_true_o,
  output logic                               divide_by_zero_o
);

  localparam int unsigned NumW = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned Dly  = NumW;
  localparam int unsigned Lat  = NumW + 4;

  assign busy = 1'b0;

  // Stage 0: register the beat.
  logic                         v0_q;
  fpa_pkg::cmd_e                cmd0_q;
  logic signed [DATA_WIDTH-1:0] a0_q, b0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd0_q <= fpa_pkg::cmd_e'(cmd_i);
    a0_q   <= operand_a_i[DATA_WIDTH-1:0];
    b0_q   <= operand_b_i[DATA_WIDTH-1:0];
  end

  // Stage 1: simple operations and the full product.
  logic signed [DATA_WIDTH-1:0] simple_d;
  logic                         cmp_d;

  always_comb begin
    simple_d = '0;
    cmp_d    = 1'b0;
    case (cmd0_q)
      fpa_pkg::CMD_ADD:      simple_d = a0_q + b0_q;
      fpa_pkg::CMD_SUB:      simple_d = a0_q - b0_q;
      fpa_pkg::CMD_GT:       cmp_d = (a0_q > b0_q);
      fpa_pkg::CMD_LT:       cmp_d = (a0_q < b0_q);
      fpa_pkg::CMD_GE:       cmp_d = (a0_q >= b0_q);
      fpa_pkg::CMD_LE:       cmp_d = (a0_q <= b0_q);
      fpa_pkg::CMD_EQ:       cmp_d = (a0_q == b0_q);
      fpa_pkg::CMD_NE:       cmp_d = (a0_q != b0_q);
      fpa_pkg::CMD_MIN:      simple_d = (a0_q < b0_q) ? a0_q : b0_q;
      fpa_pkg::CMD_MAX:      simple_d = (a0_q > b0_q) ? a0_q : b0_q;
      fpa_pkg::CMD_INC:      simple_d = a0_q + DATA_WIDTH'(1);
      fpa_pkg::CMD_DEC:      simple_d = a0_q - DATA_WIDTH'(1);
      fpa_pkg::CMD_FROM_INT: simple_d = a0_q <<< FRAC_BITS;
      fpa_pkg::CMD_TO_INT:   simple_d = a0_q >>> FRAC_BITS;
      default:               simple_d = '0;
    endcase
  end

  logic                           v1_q, cmp1_q;
  fpa_pkg::cmd_e                  cmd1_q;
  logic signed [DATA_WIDTH-1:0]   simple1_q;
  logic signed [2*DATA_WIDTH-1:0] prod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q    <= cmd0_q;
    cmp1_q    <= cmp_d;
    simple1_q <= simple_d;
    prod1_q   <= (2*DATA_WIDTH)'(a0_q) * (2*DATA_WIDTH)'(b0_q);
  end

  // Stage 2: scale the product and pick the non-divide result.
  logic signed [2*DATA_WIDTH-1:0] prod_sh;
  assign prod_sh = prod1_q >>> FRAC_BITS;

  logic                         v2_q, cmp2_q, isdiv2_q;
  logic signed [DATA_WIDTH-1:0] res2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp2_q   <= cmp1_q;
    isdiv2_q <= (cmd1_q == fpa_pkg::CMD_DIV);
    res2_q   <= (cmd1_q == fpa_pkg::CMD_MUL) ? prod_sh[DATA_WIDTH-1:0] : simple1_q;
  end

  // Divider runs beside stages 1 and 2 and the delay line.
  fpa_pkg::div_ctl_t            div_ctl;
  logic signed [DATA_WIDTH-1:0] div_quot;

  fpa_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q && (cmd0_q == fpa_pkg::CMD_DIV)),
    .a_i    (a0_q),
    .b_i    (b0_q),
    .ctl_o  (div_ctl),
    .quot_o (div_quot)
  );

  // Delay line that lines the other results up with the divider output.
  logic                         dv_q   [Dly];
  logic                         dcmp_q [Dly];
  logic                         ddiv_q [Dly];
  logic signed [DATA_WIDTH-1:0] dres_q [Dly];

  for (genvar k = 0; k < Dly; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= (k == 0) ? v2_q : dv_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (k == 0) begin
        dcmp_q[k] <= cmp2_q;
        ddiv_q[k] <= isdiv2_q;
        dres_q[k] <= res2_q;
      end else begin
        dcmp_q[k] <= dcmp_q[(k == 0) ? 0 : k-1];
        ddiv_q[k] <= ddiv_q[(k == 0) ? 0 : k-1];
        dres_q[k] <= dres_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Output stage: merge the divider result and drive the strobe.
  logic                         out_v_q, out_cmp_q, out_dz_q;
  logic signed [DATA_WIDTH-1:0] out_res_q;
  logic                         last_div;
  assign last_div = ddiv_q[Dly-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_q[Dly-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmp_q <= dcmp_q[Dly-1];
    out_dz_q  <= last_div && div_ctl.div_zero;
    out_res_q <= last_div ? div_quot : dres_q[Dly-1];
  end

  assign result_valid_o   = out_v_q;
  assign result_value_o   = fpa_pkg::FieldW'(out_res_q);
  assign compare_true_o   = out_cmp_q;
  assign divide_by_zero_o = out_dz_q;

  // A divide beat must line up with the divider's valid output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[Dly-1] && last_div |-> div_ctl.valid)
    else $error("divider output out of step with delay line");

  // Every result follows an accepted beat by the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, Lat))
    else $error("result without a matching start");

  // A compare never also reports divide by zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(compare_true_o && divide_by_zero_o))
    else $error("compare and divide-by-zero both set");

  // Divide by zero always gives a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && divide_by_zero_o |-> result_value_o == '0)
    else $error("nonzero value on divide by zero");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Q24.8 fixed-point ALU core.
// Depends on fpa_pkg and fixed_point_alu_core; drives directed then random beats.
module testbench;

  localparam int unsigned Latency  = fpa_pkg::DataWidth + fpa_pkg::FracBits + 4;
  localparam int unsigned CycleCap = 200000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_result_t;

  typedef struct {
    fpa_pkg::cmd_e      op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;
    alu_result_t        res;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [fpa_pkg::CmdW-1:0] cmd_i = '0;
  logic signed [31:0]       operand_a_i = '0;
  logic signed [31:0]       operand_b_i = '0;
  logic                     result_valid_o;
  logic signed [31:0]       result_value_o;
  logic                     compare_true_o;
  logic                     divide_by_zero_o;

  alu_result_t expected_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  stim_row_t   directed[$];

  fixed_point_alu_core DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .operand_a_i, .operand_b_i,
    .result_valid_o, .result_value_o, .compare_true_o, .divide_by_zero_o
  );

  always #6 clk_i = ~clk_i;

  // Work out what one beat should produce.
  function automatic alu_result_t compute_alu(fpa_pkg::cmd_e op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t        r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    r = '0;
    case (op)
      fpa_pkg::CMD_ADD:      r.value = a + b;
      fpa_pkg::CMD_SUB:      r.value = a - b;
      fpa_pkg::CMD_MUL: begin
        prod    = 64'(a) * 64'(b);
        r.value = 32'(prod >>> fpa_pkg::FracBits);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num     = 64'(a) <<< fpa_pkg::FracBits;
          r.value = 32'(num / 64'(b));
        end
      end
      fpa_pkg::CMD_GT:       r.cmp = a > b;
      fpa_pkg::CMD_LT:       r.cmp = a < b;
      fpa_pkg::CMD_GE:       r.cmp = a >= b;
      fpa_pkg::CMD_LE:       r.cmp = a <= b;
      fpa_pkg::CMD_EQ:       r.cmp = a == b;
      fpa_pkg::CMD_NE:       r.cmp = a != b;
      fpa_pkg::CMD_MIN:      r.value = (a < b) ? a : b;
      fpa_pkg::CMD_MAX:      r.value = (a > b) ? a : b;
      fpa_pkg::CMD_INC:      r.value = a + 1;
      fpa_pkg::CMD_DEC:      r.value = a - 1;
      fpa_pkg::CMD_FROM_INT: r.value = a <<< fpa_pkg::FracBits;
      default:               r.value = a >>> fpa_pkg::FracBits;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (result_value_o !== e.value)
          report_mismatch($sformatf("value %h, expected %h", result_value_o, e.value));
        if (compare_true_o !== e.cmp)
          report_mismatch($sformatf("compare %b, expected %b", compare_true_o, e.cmp));
        if (divide_by_zero_o !== e.dz)
          report_mismatch($sformatf("div zero %b, expected %b", divide_by_zero_o, e.dz));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleCap) begin
      $display("fixed_point_alu_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      default: return $urandom;
    endcase
  endfunction

  // Hand one beat to the block, waiting for acceptance.
  task automatic send_beat(fpa_pkg::cmd_e op, logic signed [31:0] a,
                           logic signed [31:0] b, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(compute_alu(op, a, b));
    @(negedge clk_i);
  endtask

  task automatic add_row(fpa_pkg::cmd_e op, logic signed [31:0] a, logic signed [31:0] b,
                         bit known, alu_result_t res);
    stim_row_t row;
    row.op = op; row.a = a; row.b = b; row.known = known; row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    alu_result_t chk;
    int          n;
    // Directed rows: extremes, every operation, divide by zero, wrapping.
    add_row(fpa_pkg::CMD_ADD, 32'sh7fff_ffff, 32'sd1, 1,
            '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_SUB, 32'sh8000_0000, 32'sd1, 1,
            '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_MUL, 32'sh0000_0100, 32'sh0000_0100, 1,
            '{32'sh0000_0100, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_MUL, 32'sh8000_0000, 32'sh8000_0000, 0, '0);
    add_row(fpa_pkg::CMD_MUL, -32'sd1, 32'sd1, 1, '{-32'sd1, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_DIV, 32'sd1234, 32'sd0, 1, '{32'sd0, 1'b0, 1'b1});
    add_row(fpa_pkg::CMD_DIV, 32'sh8000_0000, -32'sd1, 0, '0);
    add_row(fpa_pkg::CMD_DIV, -32'sd3, 32'sh0000_0200, 0, '0);
    add_row(fpa_pkg::CMD_GT, 32'sh7fff_ffff, 32'sh8000_0000, 1, '{32'sd0, 1'b1, 1'b0});
    add_row(fpa_pkg::CMD_LT, 32'sh7fff_ffff, 32'sh8000_0000, 1, '{32'sd0, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_GE, 32'sd5, 32'sd5, 1, '{32'sd0, 1'b1, 1'b0});
    add_row(fpa_pkg::CMD_LE, 32'sd6, 32'sd5, 1, '{32'sd0, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_EQ, 32'sh8000_0000, 32'sh8000_0000, 1, '{32'sd0, 1'b1, 1'b0});
    add_row(fpa_pkg::CMD_NE, 32'sd0, 32'sd0, 1, '{32'sd0, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1,
            '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1,
            '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_INC, 32'sh7fff_ffff, 32'sd0, 1, '{32'sh8000_0000, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_DEC, 32'sh8000_0000, -32'sd1, 1, '{32'sh7fff_ffff, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_FROM_INT, 32'sd3, 32'sd0, 1, '{32'sh0000_0300, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_FROM_INT, 32'sh7fff_ffff, 32'sd0, 0, '0);
    add_row(fpa_pkg::CMD_TO_INT, -32'sd1, 32'sd0, 1, '{-32'sd1, 1'b0, 1'b0});
    add_row(fpa_pkg::CMD_TO_INT, 32'sh8000_0000, 32'sh7fff_ffff, 1,
            '{32'shff80_0000, 1'b0, 1'b0});

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the table; typed-in results also cross-check the predictor.
    foreach (directed[i]) begin
      if (directed[i].known) begin
        chk = compute_alu(directed[i].op, directed[i].a, directed[i].b);
        if (chk !== directed[i].res)
          report_mismatch($sformatf("table row %0d disagrees with predictor", i));
      end
      send_beat(directed[i].op, directed[i].a, directed[i].b, 1'b1);
    end

    // Random beats; the last stretch runs back to back.
    n = 1400;
    for (int i = 0; i < n; i++)
      send_beat(fpa_pkg::cmd_e'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                i < n - 200);
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("fixed_point_alu_core verification clean");
    end else begin
      $display("fixed_point_alu_core verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
src/fpa_pkg.sv
src/fpa_div.sv
src/fixed_point_alu_core.sv
tb/sv/testbench.sv
